// File: src/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg: shared definitions of the color key blitter
// Widths, register indexes and the settings bundle that the configuration
// block hands to the pixel path.
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

  localparam int MaxDim   = 2048;
  localparam int DimW     = $clog2(MaxDim);
  localparam int AddrW    = 22;
  localparam int PixW     = 32;
  localparam int ColorW   = 24;
  localparam int PosW     = 11;
  localparam int StrideW  = 12;
  localparam int SizeW    = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int ProdW    = PosW + StrideW;

  localparam logic [ColorW-1:0] ColorMask = 24'hff_ffff;

  localparam logic [CfgIdxW-1:0] RegDestX      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDestY      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDestStride = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCopyWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCopyHeight = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKeyColor   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegKeyMode    = 3'd6;

  typedef struct packed {
    logic [AddrW-1:0]   origin;
    logic [StrideW-1:0] stride;
    logic [DimW-1:0]    col_last;
    logic [DimW-1:0]    row_last;
    logic [ColorW-1:0]  key_color;
    logic               key_mode;
    logic               block_input;
  } ckb_cfg_t;

  // Index of the last column or row for a programmed size; zero acts as one
  // and anything above the maximum acts as the maximum.
  function automatic logic [DimW-1:0] last_index(input logic [SizeW-1:0] size);
    logic [DimW-1:0] res;
    if (size == '0) begin
      res = '0;
    end else if (32'(size) > MaxDim) begin
      res = DimW'(MaxDim - 1);
    end else begin
      res = DimW'(size - SizeW'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/color_key_blitter.sv
// ----------------------------------------------------------------------------
// color_key_blitter: color-keyed rectangle blitter
// Turns a raster stream of source pixels into destination writes.
// ----------------------------------------------------------------------------
// One source word is taken per clock and one destination write comes out per
// clock, while the output is not stalled and the input is not closed for a
// configuration write. A word is held in the input register when it is
// accepted, and its write is loaded into the output register once the output
// is free and shown from there. While a result waits, the input register can
// take one more word, and then the input closes until the output moves.
// The destination origin (dest_y times stride plus dest_x) and the clamped
// rectangle size are held in registers computed from the configuration, so
// the input word channel is closed during a configuration write and the
// cycle after it. Rows advance by adding the stride to the row start address;
// every address wraps at 22 bits.
`default_nettype none

module color_key_blitter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ckb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ckb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ckb_pkg::PixW-1:0]     src_pixel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ckb_pkg::AddrW-1:0]         dest_address_o,
  output logic [ckb_pkg::PixW-1:0]          write_pixel_o,
  output logic                              write_enable_o,
  output logic                              last_pixel_o
);
  import ckb_pkg::*;

  ckb_cfg_t cfg;

  ckb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ckb_pixel_path u_pixel_path (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_pixel_i    (src_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_address_o (dest_address_o),
    .write_pixel_o  (write_pixel_o),
    .write_enable_o (write_enable_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

`default_nettype wire

// File: src/ckb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ckb_cfg_regs: configuration registers
// Holds the programmed registers and registers the derived origin address
// and the last column and row indexes for the pixel path.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ckb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ckb_pkg::CfgDataW-1:0] cfg_data_i,
  output ckb_pkg::ckb_cfg_t                 cfg_o
);
  import ckb_pkg::*;

  logic [PosW-1:0]    dest_x_q, dest_y_q;
  logic [StrideW-1:0] stride_q;
  logic [SizeW-1:0]   width_q, height_q;
  logic [ColorW-1:0]  key_color_q;
  logic               key_mode_q;
  logic [AddrW-1:0]   origin_q;
  logic [DimW-1:0]    col_last_q, row_last_q;
  logic               settle_q;
  logic [ProdW-1:0]   row_offset;
  logic               cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign row_offset  = ProdW'(dest_y_q) * ProdW'(stride_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q    <= '0;
      dest_y_q    <= '0;
      stride_q    <= StrideW'(2048);
      width_q     <= SizeW'(1);
      height_q    <= SizeW'(1);
      key_color_q <= '0;
      key_mode_q  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        RegDestX:      dest_x_q    <= cfg_data_i[PosW-1:0];
        RegDestY:      dest_y_q    <= cfg_data_i[PosW-1:0];
        RegDestStride: stride_q    <= cfg_data_i[StrideW-1:0];
        RegCopyWidth:  width_q     <= cfg_data_i[SizeW-1:0];
        RegCopyHeight: height_q    <= cfg_data_i[SizeW-1:0];
        RegKeyColor:   key_color_q <= cfg_data_i[ColorW-1:0] & ColorMask;
        RegKeyMode:    key_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Derived values are registered from the programmed registers; settle_q keeps
  // the input closed until they have caught up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q   <= '0;
      col_last_q <= '0;
      row_last_q <= '0;
      settle_q   <= 1'b0;
    end else begin
      origin_q   <= row_offset[AddrW-1:0] + AddrW'(dest_x_q);
      col_last_q <= last_index(width_q);
      row_last_q <= last_index(height_q);
      settle_q   <= cfg_write;
    end
  end

  always_comb begin
    cfg_o.origin      = origin_q;
    cfg_o.stride      = stride_q;
    cfg_o.col_last    = col_last_q;
    cfg_o.row_last    = row_last_q;
    cfg_o.key_color   = key_color_q;
    cfg_o.key_mode    = key_mode_q;
    cfg_o.block_input = cfg_valid_i | settle_q;
  end

endmodule

`default_nettype wire

// File: src/ckb_pixel_path.sv
// ----------------------------------------------------------------------------
// ckb_pixel_path: pixel pipeline
// Input register, raster counters and address/key logic feeding the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_pixel_path (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ckb_pkg::ckb_cfg_t         cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [ckb_pkg::PixW-1:0]  src_pixel_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [ckb_pkg::AddrW-1:0]      dest_address_o,
  output logic [ckb_pkg::PixW-1:0]       write_pixel_o,
  output logic                           write_enable_o,
  output logic                           last_pixel_o
);
  import ckb_pkg::*;

  logic             s1_valid_q;
  logic [PixW-1:0]  s1_pixel_q;
  logic [DimW-1:0]  col_q, row_q;
  logic [AddrW-1:0] row_start_q;
  logic             out_valid_q;
  logic [AddrW-1:0] addr_q;
  logic [PixW-1:0]  pixel_q;
  logic             we_q, last_q;

  logic             out_free, s1_move, in_take;
  logic             first, row_end, last;
  logic [AddrW-1:0] row_base, addr_d;
  logic [PixW-1:0]  pixel_d;
  logic             we_d;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_move    = s1_valid_q & out_free;
  assign in_ready_o = (~s1_valid_q | out_free) & ~cfg_i.block_input;
  assign in_take    = in_valid_i & in_ready_o;

  always_comb begin
    first    = (col_q == '0) && (row_q == '0);
    row_base = first ? cfg_i.origin : row_start_q;
    addr_d   = row_base + AddrW'(col_q);
    row_end  = col_q >= cfg_i.col_last;
    last     = row_end && (row_q >= cfg_i.row_last);
    if (cfg_i.key_mode) begin
      pixel_d = {{(PixW-ColorW){1'b0}}, s1_pixel_q[ColorW-1:0]};
      we_d    = s1_pixel_q[ColorW-1:0] != cfg_i.key_color;
    end else begin
      pixel_d = s1_pixel_q;
      we_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      row_start_q <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (s1_move) begin
        if (last) begin
          col_q       <= '0;
          row_q       <= '0;
          row_start_q <= cfg_i.origin;
        end else if (row_end) begin
          col_q       <= '0;
          row_q       <= row_q + DimW'(1);
          row_start_q <= row_base + AddrW'(cfg_i.stride);
        end else begin
          col_q       <= col_q + DimW'(1);
          row_start_q <= row_base;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pixel_q <= src_pixel_i;
    end
    if (s1_move) begin
      addr_q  <= addr_d;
      pixel_q <= pixel_d;
      we_q    <= we_d;
      last_q  <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = addr_q;
  assign write_pixel_o  = pixel_q;
  assign write_enable_o = we_q;
  assign last_pixel_o   = last_q;

endmodule

`default_nettype wire

// File: src/ckb_checker.sv
// ----------------------------------------------------------------------------
// ckb_checker: port-level checks of the color key blitter
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [ckb_pkg::AddrW-1:0]    dest_address_o,
  input wire logic [ckb_pkg::PixW-1:0]     write_pixel_o,
  input wire logic                         write_enable_o,
  input wire logic                         last_pixel_o
);

  // A stalled word keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dest_address_o)
      && $stable(write_pixel_o) && $stable(write_enable_o) && $stable(last_pixel_o))
    else $error("output word changed while stalled");

  // The input stays closed in the cycle after a write, while the derived origin settles.
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input open right after a configuration write");

  // A nonzero alpha byte means plain mode, which always writes.
  a_alpha_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (write_pixel_o[31:24] != 8'h00) |-> write_enable_o)
    else $error("plain-mode word not written");

  // A skipped pixel only happens in keyed mode, where alpha is cleared.
  a_skip_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> write_pixel_o[31:24] == 8'h00)
    else $error("skipped word still carries alpha");

endmodule

bind color_key_blitter ckb_checker u_ckb_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pixel stream check of color_key_blitter
// A scoreboard class mirrors the blitter's counters and registers and
// predicts the destination write for every source word taken. Registers are
// rewritten between phases, sometimes in the middle of a rectangle, while
// both sides of the pixel stream idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ckb_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int RandomWords = 400;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pixel;
    logic             we;
    logic             last;
  } dest_write_t;

  typedef enum logic [1:0] {RxFlow, RxCoin, RxBeat, RxRare} rx_mode_t;

  class blit_scoreboard;
    logic [PosW-1:0]    dest_x, dest_y;
    logic [StrideW-1:0] stride;
    logic [SizeW-1:0]   width, height;
    logic [ColorW-1:0]  key;
    logic               keyed;
    int unsigned        col, row;
    logic [AddrW-1:0]   row_addr;
    dest_write_t        pending_writes[$];
    int                 fail_count;

    function new();
      dest_x     = '0;
      dest_y     = '0;
      stride     = 12'd2048;
      width      = 12'd1;
      height     = 12'd1;
      key        = '0;
      keyed      = 1'b0;
      col        = 0;
      row        = 0;
      row_addr   = origin();
      fail_count = 0;
    endfunction

    function logic [AddrW-1:0] origin();
      int unsigned sum;
      sum = int'(dest_y) * int'(stride) + int'(dest_x);
      return AddrW'(sum);
    endfunction

    // Zero acts as one, and anything above the maximum as the maximum.
    function int unsigned dim(logic [SizeW-1:0] size);
      if (size == '0) return 1;
      if (size > MaxDim) return MaxDim;
      return int'(size);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegDestX:      dest_x = data[PosW-1:0];
        RegDestY:      dest_y = data[PosW-1:0];
        RegDestStride: stride = data[StrideW-1:0];
        RegCopyWidth:  width  = data[SizeW-1:0];
        RegCopyHeight: height = data[SizeW-1:0];
        RegKeyColor:   key    = data[ColorW-1:0];
        RegKeyMode:    keyed  = data[0];
        default: ;
      endcase
    endfunction

    // Words still needed to reach the final pixel of the current rectangle.
    function int unsigned pixels_to_finish();
      int unsigned w, h, in_row;
      w = dim(width);
      h = dim(height);
      in_row = (col >= w - 1) ? 1 : w - col;
      if (row >= h - 1) return in_row;
      return in_row + (h - 1 - row) * w;
    endfunction

    function void note_pixel(logic [PixW-1:0] src);
      int unsigned w, h;
      dest_write_t want;
      logic        row_end;
      w = dim(width);
      h = dim(height);
      if (col == 0 && row == 0) row_addr = origin();
      want.addr = row_addr + AddrW'(col);
      if (keyed) begin
        want.pixel = {8'h00, src[ColorW-1:0] & ColorMask};
        want.we    = (src[ColorW-1:0] != key);
      end else begin
        want.pixel = src;
        want.we    = 1'b1;
      end
      row_end   = (col >= w - 1);
      want.last = row_end && (row >= h - 1);
      pending_writes.push_back(want);
      if (want.last) begin
        col      = 0;
        row      = 0;
        row_addr = origin();
      end else if (row_end) begin
        col      = 0;
        row      = row + 1;
        row_addr = row_addr + AddrW'(stride);
      end else begin
        col = col + 1;
      end
    endfunction

    function void note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_write(dest_write_t got);
      dest_write_t want;
      if (pending_writes.size() == 0) begin
        note_fail($sformatf("write to %h with none expected", got.addr));
        return;
      end
      want = pending_writes.pop_front();
      if (want.addr !== got.addr || want.pixel !== got.pixel ||
          want.we !== got.we || want.last !== got.last) begin
        note_fail($sformatf({"expected addr %h pixel %h we %b last %b, ",
                             "got addr %h pixel %h we %b last %b"},
                            want.addr, want.pixel, want.we, want.last,
                            got.addr, got.pixel, got.we, got.last));
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  logic [PixW-1:0]     src_pixel = '0;
  logic                wr_valid;
  logic                wr_ready = 1'b0;
  logic [AddrW-1:0]    wr_address;
  logic [PixW-1:0]     wr_pixel;
  logic                wr_enable;
  logic                wr_last;

  blit_scoreboard sb = new();
  int       cycles = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RxFlow;
  int       rx_left = 0;
  int       rx_beat = 0;

  color_key_blitter u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (pix_valid),
    .in_ready_o     (pix_ready),
    .src_pixel_i    (src_pixel),
    .out_valid_o    (wr_valid),
    .out_ready_i    (wr_ready),
    .dest_address_o (wr_address),
    .write_pixel_o  (wr_pixel),
    .write_enable_o (wr_enable),
    .last_pixel_o   (wr_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Every handshake is observed here, on the values present before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (pix_valid && pix_ready) sb.note_pixel(src_pixel);
      if (wr_valid && wr_ready) sb.check_write({wr_address, wr_pixel, wr_enable, wr_last});
    end
  end

  // The write side switches among steady flow, coin flips, a fixed beat and
  // rare stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 300);
    end
    rx_left--;
    rx_beat++;
    case (rx_mode)
      RxFlow:  wr_ready <= 1'b1;
      RxCoin:  wr_ready <= 1'($urandom_range(0, 1));
      RxBeat:  wr_ready <= (rx_beat % 5) > 1;
      default: wr_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the word is
  // taken, with valid still high.
  task automatic send_pixel(input logic [PixW-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_valid <= 1'b1;
    src_pixel <= px;
    do @(posedge clk); while (!pix_ready);
    @(negedge clk);
  endtask

  task automatic end_phase();
    pix_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  // Leaves valid high so that writes can follow back to back.
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Now and then the bits above a register's width carry junk.
  function automatic logic [CfgDataW-1:0] with_noise(int bits, logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom) & ~((CfgDataW'(1) << bits) - 1);
    return ($urandom_range(0, 3) == 0) ? (value | noise) : value;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 24'd2047;
      default: return CfgDataW'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_stride();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'd1;
      2:       return 24'd2048;
      3:       return 24'd4095;
      default: return CfgDataW'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_size(int most);
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2:       return 24'd4095;
      default: return CfgDataW'($urandom_range(1, most));
    endcase
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    if (sb.keyed && $urandom_range(0, 2) == 0) return {8'($urandom), sb.key};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic shuffle_config(input bit big);
    if ($urandom_range(0, 1)) set_reg(RegDestX, with_noise(PosW, pick_pos()));
    if ($urandom_range(0, 1)) set_reg(RegDestY, with_noise(PosW, pick_pos()));
    if ($urandom_range(0, 1)) set_reg(RegDestStride, with_noise(StrideW, pick_stride()));
    if ($urandom_range(0, 2)) begin
      set_reg(RegKeyMode, with_noise(1, CfgDataW'($urandom_range(0, 1))));
    end
    if ($urandom_range(0, 2) == 0) set_reg(RegKeyColor, CfgDataW'($urandom));
    if (big) begin
      set_reg(RegCopyWidth, CfgDataW'($urandom_range(MaxDim, 4095)));
      set_reg(RegCopyHeight, 24'd1);
    end else begin
      if ($urandom_range(0, 2)) set_reg(RegCopyWidth, with_noise(SizeW, pick_size(8)));
      if ($urandom_range(0, 2)) set_reg(RegCopyHeight, with_noise(SizeW, pick_size(5)));
    end
    if ($urandom_range(0, 15) == 0) set_reg(RegSpare, CfgDataW'($urandom));
    close_cfg();
  endtask

  initial begin
    int random_sent;
    int big_phase;
    int phase;
    int n;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers as they come out of reset.
    send_pixel(32'hffff_ffff);
    end_phase();

    // Origin at the very last address, zero sizes acting as one.
    set_reg(RegDestX, 24'd2047);
    set_reg(RegDestY, 24'd2047);
    set_reg(RegDestStride, 24'd2048);
    set_reg(RegCopyWidth, 24'd0);
    set_reg(RegCopyHeight, 24'd0);
    close_cfg();
    send_pixel(32'h0000_0000);
    send_pixel(32'h8000_0001);
    end_phase();

    // Origin and row steps wrap past the top of the address space.
    set_reg(RegDestStride, 24'd4095);
    set_reg(RegCopyWidth, 24'd3);
    set_reg(RegCopyHeight, 24'd2);
    close_cfg();
    send_pixel(32'ha5a5_a5a5);
    send_pixel(32'h5a5a_5a5a);
    send_pixel(32'hffff_fffe);
    send_pixel(32'h0000_0001);
    send_pixel(32'h7fff_ffff);
    send_pixel(32'h8000_0000);
    end_phase();

    // Keyed copy on a zero stride: every row lands on the same words.
    set_reg(RegKeyMode, 24'd1);
    set_reg(RegKeyColor, 24'hff_ffff);
    set_reg(RegDestStride, 24'd0);
    set_reg(RegDestX, 24'd0);
    set_reg(RegDestY, 24'd5);
    set_reg(RegCopyWidth, 24'd2);
    set_reg(RegCopyHeight, 24'd3);
    close_cfg();
    send_pixel(32'hffff_ffff);
    send_pixel(32'h7fab_cdef);
    send_pixel(32'h00ff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'h80ff_ffff);
    send_pixel(32'h1234_5678);
    end_phase();

    // A black key: an opaque alpha byte alone does not make a pixel visible.
    set_reg(RegKeyColor, 24'h00_0000);
    set_reg(RegCopyWidth, 24'd1);
    set_reg(RegCopyHeight, 24'd1);
    close_cfg();
    send_pixel(32'hff00_0000);
    send_pixel(32'h0000_0001);
    end_phase();

    // Shrink the rectangle while it is half done; the spare index is ignored.
    set_reg(RegKeyMode, 24'd0);
    set_reg(RegDestX, 24'd10);
    set_reg(RegDestY, 24'd3);
    set_reg(RegDestStride, 24'd100);
    set_reg(RegCopyWidth, 24'd4);
    set_reg(RegCopyHeight, 24'd3);
    close_cfg();
    repeat (6) send_pixel(rand_pixel());
    end_phase();
    set_reg(RegCopyWidth, 24'd2);
    set_reg(RegDestStride, 24'd7);
    set_reg(RegSpare, 24'hff_ffff);
    close_cfg();
    send_pixel(rand_pixel());
    end_phase();
    set_reg(RegCopyHeight, 24'd1);
    set_reg(RegDestX, 24'd0);
    close_cfg();
    repeat (3) send_pixel(rand_pixel());
    end_phase();

    // Random phases; one of them programs a width at or above the maximum.
    random_sent = 0;
    big_phase = $urandom_range(1, 6);
    phase = 0;
    while (random_sent < RandomWords) begin
      shuffle_config(phase == big_phase);
      n = sb.pixels_to_finish();
      if (n > 64) n = 64;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      random_sent += n;
      repeat (n) send_pixel(rand_pixel());
      end_phase();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/ckb_pkg.sv
src/ckb_cfg_regs.sv
src/ckb_pixel_path.sv
src/color_key_blitter.sv
src/ckb_checker.sv
sim/testbench.sv
